@@ rtl/lz77td_pkg.sv @@
// Package for the LZ77 triple decoder: word types and controller interface structs.
// No dependencies; every other file of the block refers to it by scoped names.
`timescale 1ns / 1ps

package lz77td_pkg;

    // One input word: a back reference plus a trailing literal.
    typedef struct packed {
        logic [11:0] back_distance;
        logic [5:0]  copy_length;
        logic [7:0]  literal_byte;
    } in_word_t;

    // One output word: a decoded byte with its framing flags.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last;
        logic       bad_reference;
    } out_word_t;

    localparam int unsigned DIST_W = 12;
    localparam int unsigned LEN_W  = 6;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take;       // latch the incoming triple and start the first history read
        logic copy_emit;  // move the fetched history byte to the output and read the next
        logic lit_emit;   // move the literal to the output
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic ref_bad;    // incoming triple has an invalid reference
        logic copy_none;  // incoming triple copies nothing
        logic last_copy;  // the copy in progress is on its final byte
        logic out_free;   // the output register can take a word this cycle
    } ctrl_sts_t;

endpackage

@@ rtl/lz77_triple_decoder.sv @@
// LZ77 triple decoder. Bytes are registered in the output register before they show on m_valid.
// Throughput: one byte per cycle within a triple while m_ready stays high. A triple is handled
// as: take it and start the first history read, then each copied byte, then the literal; the
// next triple is taken only once the literal has gone out.
// Reset (aresetn, synchronous, active low) clears the pointer, fill count, state and m_valid;
// the history memory is not cleared and needs no clearing pass. Depends on lz77td_pkg.
`timescale 1ns / 1ps

module lz77_triple_decoder #(
    parameter int unsigned WINDOW     = 4096,
    parameter int unsigned MAX_LENGTH = 63
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  lz77td_pkg::in_word_t  s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output lz77td_pkg::out_word_t m_data
);

    lz77td_pkg::ctrl_cmd_t cmd;
    lz77td_pkg::ctrl_sts_t sts;

    lz77td_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    lz77td_datapath #(
        .WINDOW     (WINDOW),
        .MAX_LENGTH (MAX_LENGTH)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .cmd     (cmd),
        .sts     (sts)
    );

endmodule

@@ rtl/lz77td_ctrl.sv @@
// Controller state machine of the LZ77 triple decoder.
// Depends on lz77td_pkg for the command and status structs.
`timescale 1ns / 1ps

module lz77td_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  lz77td_pkg::ctrl_sts_t sts,
    output lz77td_pkg::ctrl_cmd_t cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_COPY,
        ST_LIT
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb begin
        state_next    = state_reg;
        cmd           = '0;
        s_ready       = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.take = s_valid;
                if (s_valid) begin
                    if (sts.ref_bad || sts.copy_none) begin
                        state_next = ST_LIT;
                    end else begin
                        state_next = ST_COPY;
                    end
                end
            end
            ST_COPY: begin
                cmd.copy_emit = sts.out_free;
                if (sts.out_free && sts.last_copy) begin
                    state_next = ST_LIT;
                end
            end
            ST_LIT: begin
                cmd.lit_emit = sts.out_free;
                if (sts.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

@@ rtl/lz77td_datapath.sv @@
// Datapath of the LZ77 triple decoder: history memory, pointers, fill count, output register.
// Depends on lz77td_pkg for word types and the command and status structs.
`timescale 1ns / 1ps

module lz77td_datapath #(
    parameter int unsigned WINDOW     = 4096,
    parameter int unsigned MAX_LENGTH = 63
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  lz77td_pkg::in_word_t  s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output lz77td_pkg::out_word_t m_data,
    input  lz77td_pkg::ctrl_cmd_t cmd,
    output lz77td_pkg::ctrl_sts_t sts
);

    localparam int unsigned PTR_W  = $clog2(WINDOW);
    localparam int unsigned FILL_W = $clog2(WINDOW + 1);
    localparam int unsigned CW     =
        ((PTR_W > lz77td_pkg::DIST_W) ? PTR_W : lz77td_pkg::DIST_W) + 1;
    localparam int unsigned LEN_W  = lz77td_pkg::LEN_W;

    logic [7:0]        hist_mem [WINDOW];
    logic [7:0]        rdata_reg;

    logic [PTR_W-1:0]  wp_reg, wp_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [PTR_W-1:0]  src_reg, src_next;
    logic [LEN_W-1:0]  remain_reg, remain_next;
    logic [7:0]        lit_reg;
    logic              bad_reg;
    logic              m_valid_reg, m_valid_next;
    lz77td_pkg::out_word_t m_data_reg;

    logic [LEN_W-1:0]  len_clamped;
    logic [CW-1:0]     dist_ext, fill_ext, wp_ext, src_wide;
    logic [PTR_W-1:0]  src_start, src_inc, rd_addr;
    logic              rd_en, wr_en;
    logic [7:0]        wr_data;

    always_comb begin
        if (s_data.copy_length > LEN_W'(MAX_LENGTH)) begin
            len_clamped = LEN_W'(MAX_LENGTH);
        end else begin
            len_clamped = s_data.copy_length;
        end
        dist_ext = CW'(s_data.back_distance);
        fill_ext = CW'(fill_reg);
        wp_ext   = CW'(wp_reg);
        // Start of the copy, wrapped around the ring; only meaningful when the reference is valid.
        if (wp_ext >= dist_ext) begin
            src_wide = wp_ext - dist_ext;
        end else begin
            src_wide = wp_ext + CW'(WINDOW) - dist_ext;
        end
        src_start = src_wide[PTR_W-1:0];
        src_inc   = (src_reg == PTR_W'(WINDOW - 1)) ? '0 : src_reg + 1'b1;
    end

    assign sts.ref_bad   = (dist_ext > fill_ext) ||
                           ((s_data.back_distance == '0) && (len_clamped != '0));
    assign sts.copy_none = (len_clamped == '0);
    assign sts.last_copy = (remain_reg == LEN_W'(1));
    assign sts.out_free  = !m_valid_reg || m_ready;

    assign rd_en   = cmd.take || cmd.copy_emit;
    assign rd_addr = cmd.take ? src_start : src_inc;
    assign wr_en   = cmd.copy_emit || cmd.lit_emit;
    assign wr_data = cmd.copy_emit ? rdata_reg : lit_reg;

    always_comb begin
        wp_next      = wp_reg;
        fill_next    = fill_reg;
        src_next     = src_reg;
        remain_next  = remain_reg;
        m_valid_next = m_valid_reg && !m_ready;
        if (cmd.take) begin
            src_next    = src_start;
            remain_next = len_clamped;
        end
        if (cmd.copy_emit) begin
            src_next    = src_inc;
            remain_next = remain_reg - 1'b1;
        end
        if (wr_en) begin
            wp_next      = (wp_reg == PTR_W'(WINDOW - 1)) ? '0 : wp_reg + 1'b1;
            m_valid_next = 1'b1;
            if (fill_reg != FILL_W'(WINDOW)) begin
                fill_next = fill_reg + 1'b1;
            end
        end
    end

    // History ring. A read of the entry written in the same cycle takes the new byte,
    // which keeps overlapping copies at distance one correct.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            hist_mem[wp_reg] <= wr_data;
        end
        if (rd_en) begin
            if (wr_en && (rd_addr == wp_reg)) begin
                rdata_reg <= wr_data;
            end else begin
                rdata_reg <= hist_mem[rd_addr];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg      <= '0;
            fill_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            wp_reg      <= wp_next;
            fill_reg    <= fill_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        src_reg    <= src_next;
        remain_reg <= remain_next;
        if (cmd.take) begin
            lit_reg <= s_data.literal_byte;
            bad_reg <= sts.ref_bad;
        end
        if (cmd.copy_emit) begin
            m_data_reg.data_byte     <= rdata_reg;
            m_data_reg.last          <= 1'b0;
            m_data_reg.bad_reference <= 1'b0;
        end else if (cmd.lit_emit) begin
            m_data_reg.data_byte     <= lit_reg;
            m_data_reg.last          <= 1'b1;
            m_data_reg.bad_reference <= bad_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

@@ rtl/lz77td_checker.sv @@
// Port-level checker for the LZ77 triple decoder, bound to the top level.
// Depends on lz77td_pkg for the word types.
`timescale 1ns / 1ps

module lz77td_checker (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_valid,
    input logic                  s_ready,
    input lz77td_pkg::in_word_t  s_data,
    input logic                  m_valid,
    input logic                  m_ready,
    input lz77td_pkg::out_word_t m_data
);

    // A waiting input word holds.
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_data))
        else $error("input word changed while waiting");

    // A stalled output word holds.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("output word changed while stalled");

    // Only one triple is decoded at a time.
    a_one_triple: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while a triple was still being decoded");

    // The error flag only rides on the literal.
    a_bad_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.bad_reference |-> m_data.last)
        else $error("bad_reference set on a copied byte");

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid after reset");

endmodule

bind lz77_triple_decoder lz77td_checker u_checker (.*);
